FILE: sv/arming_interlock_fsm_defines.svh
// assertion macros shared by the arming interlock checker files
`ifndef ARMING_INTERLOCK_FSM_DEFINES_SVH
`define ARMING_INTERLOCK_FSM_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge outside reset
`define AIF_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("aif check failed");

// next-cycle implication
`define AIF_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("aif check failed");

`endif

FILE: sv/aif_pkg.sv
// types, codes and constants of the arming interlock
package aif_pkg;

   localparam int TICK_WIDTH = 32;
   localparam int HOLD_WIDTH = 16;
   localparam int ADDR_WIDTH = 3;
   localparam int DATA_WIDTH = 32;

   localparam logic [HOLD_WIDTH-1:0] HOLD_RESET = 16'd1000;

   // register index taken from the word address
   localparam logic REG_ARM_HOLD = 1'b0;

   typedef enum logic [1:0] {
      MODE_FAILSAFE = 2'd0,
      MODE_DISARMED = 2'd1,
      MODE_WAIT     = 2'd2,
      MODE_ARMED    = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      REASON_NONE    = 3'd0,
      REASON_IMU     = 3'd1,
      REASON_RC      = 3'd2,
      REASON_SWLOW   = 3'd3,
      REASON_SWNHIGH = 3'd4,
      REASON_MOTOR   = 3'd5,
      REASON_CTRL    = 3'd6
   } reason_type;

   typedef enum logic {
      OP_UPDATE = 1'b0,
      OP_FORCE  = 1'b1
   } op_type;

   typedef struct packed {
      op_type                  operation;
      logic                    imu_ok;
      logic                    rc_connected;
      logic                    switch_down;
      logic                    switch_up;
      logic                    throttle_idle;
      logic [TICK_WIDTH-1:0]   now_tick;
      logic                    authorize_ok;
      logic [2:0]              force_reason;
   } item_type;

   typedef struct packed {
      mode_type                mode;
      logic [TICK_WIDTH-1:0]   begin_tick;
      logic                    seen_low;
      reason_type              reason;
   } ctx_type;

   typedef struct packed {
      mode_type                safety_state;
      reason_type              stop_reason;
      logic                    inhibit_cmd;
      logic                    stop_cmd;
      logic                    authorize_cmd;
      logic                    zero_yaw_cmd;
   } result_type;

endpackage

FILE: sv/arming_interlock_fsm.sv
// arming interlock top level: input register, decision logic, result register
//
//   channel   direction   handshake              payload
//   req       in          req_valid/req_ready    operation, sensor flags, tick, reason
//   rsp       out         rsp_valid/rsp_ready    state, reason, command pulses
//   csr       in          psel/penable/pwrite    arm_hold_ticks at byte address 0
//
// one beat per cycle while rsp_ready keeps up; a beat passes through the input
// register and then sits in the result register, where rsp_valid offers it.
// the interlock state updates as a beat moves into the result register.
// a stalled result holds the input register; a third beat waits on req_ready.
// synchronous reset returns to failsafe with a hold time of 1000 ticks.
module arming_interlock_fsm import aif_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_operation,
   input  logic                    req_imu_ok,
   input  logic                    req_rc_connected,
   input  logic                    req_switch_down,
   input  logic                    req_switch_up,
   input  logic                    req_throttle_idle,
   input  logic [31:0]             req_now_tick,
   input  logic                    req_authorize_ok,
   input  logic [2:0]              req_force_reason,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [1:0]              rsp_safety_state,
   output logic [2:0]              rsp_stop_reason,
   output logic                    rsp_inhibit_cmd,
   output logic                    rsp_stop_cmd,
   output logic                    rsp_authorize_cmd,
   output logic                    rsp_zero_yaw_cmd,
   output logic                    rsp_is_armed,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [ADDR_WIDTH-1:0]   paddr,
   input  logic [DATA_WIDTH-1:0]   pwdata,
   output logic [DATA_WIDTH-1:0]   prdata,
   output logic                    pready
);

   logic [HOLD_WIDTH-1:0] arm_hold;

   logic       in_valid_ff;
   logic       in_valid_in;
   item_type   in_item_ff;
   item_type   in_item_in;
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type out_ff;
   result_type out_in;
   ctx_type    ctx_ff;
   ctx_type    ctx_in;
   ctx_type    ctx_next;
   result_type result;
   logic       advance;
   logic       req_take;

   aif_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .arm_hold (arm_hold)
   );

   aif_decide u_decide (
      .item     (in_item_ff),
      .ctx      (ctx_ff),
      .arm_hold (arm_hold),
      .ctx_next (ctx_next),
      .result   (result)
   );

   // beat leaves the input register when the result register is free or is being read out
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_item_in.operation     = op_type'(req_operation);
      in_item_in.imu_ok        = req_imu_ok;
      in_item_in.rc_connected  = req_rc_connected;
      in_item_in.switch_down   = req_switch_down;
      in_item_in.switch_up     = req_switch_up;
      in_item_in.throttle_idle = req_throttle_idle;
      in_item_in.now_tick      = TICK_WIDTH'(req_now_tick);
      in_item_in.authorize_ok  = req_authorize_ok;
      in_item_in.force_reason  = req_force_reason;

      in_valid_in  = req_take || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_ready);
      out_in       = advance ? result : out_ff;
      ctx_in       = advance ? ctx_next : ctx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         out_valid_ff      <= 1'b0;
         ctx_ff.mode       <= MODE_FAILSAFE;
         ctx_ff.begin_tick <= '0;
         ctx_ff.seen_low   <= 1'b0;
         ctx_ff.reason     <= REASON_NONE;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         ctx_ff       <= ctx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= in_item_in;
      end
      out_ff <= out_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_safety_state  = out_ff.safety_state;
   assign rsp_stop_reason   = out_ff.stop_reason;
   assign rsp_inhibit_cmd   = out_ff.inhibit_cmd;
   assign rsp_stop_cmd      = out_ff.stop_cmd;
   assign rsp_authorize_cmd = out_ff.authorize_cmd;
   assign rsp_zero_yaw_cmd  = out_ff.zero_yaw_cmd;
   assign rsp_is_armed      = (out_ff.safety_state == MODE_ARMED);

endmodule

FILE: sv/aif_csr.sv
// configuration register file with its bus port
module aif_csr import aif_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [ADDR_WIDTH-1:0]   paddr,
   input  logic [DATA_WIDTH-1:0]   pwdata,
   output logic [DATA_WIDTH-1:0]   prdata,
   output logic                    pready,
   output logic [HOLD_WIDTH-1:0]   arm_hold
);

   logic [HOLD_WIDTH-1:0] hold_ff;
   logic [HOLD_WIDTH-1:0] hold_in;
   logic                  wr_hit;

   assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_ARM_HOLD);

   always_comb begin
      hold_in = hold_ff;
      if (wr_hit) begin
         hold_in = pwdata[HOLD_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= HOLD_RESET;
      end else begin
         hold_ff <= hold_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_ARM_HOLD) begin
         prdata = DATA_WIDTH'(hold_ff);
      end
   end

   assign pready   = 1'b1;
   assign arm_hold = hold_ff;

endmodule

FILE: sv/aif_decide.sv
// next-state and pulse decision for one update or force beat
module aif_decide import aif_pkg::*; (
   input  item_type                item,
   input  ctx_type                 ctx,
   input  logic [HOLD_WIDTH-1:0]   arm_hold,
   output ctx_type                 ctx_next,
   output result_type              result
);

   logic [TICK_WIDTH-1:0] elapsed;
   logic                  hold_done;
   logic                  armed_now;
   logic                  do_stop;
   mode_type              stop_mode;
   reason_type            force_why;

   assign elapsed   = item.now_tick - ctx.begin_tick;
   assign hold_done = elapsed >= TICK_WIDTH'(arm_hold);
   assign armed_now = (ctx.mode == MODE_ARMED);

   // unlisted forced reasons collapse to control fault
   always_comb begin
      if (item.force_reason == REASON_IMU || item.force_reason == REASON_RC ||
          item.force_reason == REASON_MOTOR || item.force_reason == REASON_CTRL) begin
         force_why = reason_type'(item.force_reason);
      end else begin
         force_why = REASON_CTRL;
      end
   end

   always_comb begin
      ctx_next             = ctx;
      do_stop              = 1'b0;
      stop_mode            = MODE_FAILSAFE;
      result.stop_cmd      = 1'b0;
      result.authorize_cmd = 1'b0;
      result.zero_yaw_cmd  = 1'b0;

      priority if (item.operation == OP_FORCE) begin
         ctx_next.reason   = force_why;
         ctx_next.seen_low = 1'b0;
         do_stop           = 1'b1;
      end else if (!item.imu_ok) begin
         if (armed_now) ctx_next.reason = REASON_IMU;
         ctx_next.seen_low = 1'b0;
         do_stop           = 1'b1;
      end else if (!item.rc_connected) begin
         if (armed_now) ctx_next.reason = REASON_RC;
         ctx_next.seen_low = 1'b0;
         do_stop           = 1'b1;
      end else if (item.switch_down) begin
         if (armed_now) ctx_next.reason = REASON_SWLOW;
         ctx_next.seen_low = 1'b1;
         do_stop           = 1'b1;
         stop_mode         = MODE_DISARMED;
      end else if (armed_now) begin
         if (!item.switch_up) begin
            ctx_next.reason = REASON_SWNHIGH;
            do_stop         = 1'b1;
            stop_mode       = MODE_DISARMED;
         end
      end else if (!ctx.seen_low) begin
         do_stop   = 1'b1;
         stop_mode = MODE_DISARMED;
      end else if (item.switch_up && item.throttle_idle) begin
         if (ctx.mode != MODE_WAIT) begin
            ctx_next.mode       = MODE_WAIT;
            ctx_next.begin_tick = item.now_tick;
            result.stop_cmd     = 1'b1;
         end else if (hold_done) begin
            result.authorize_cmd = 1'b1;
            if (item.authorize_ok) begin
               ctx_next.mode       = MODE_ARMED;
               ctx_next.reason     = REASON_NONE;
               result.zero_yaw_cmd = 1'b1;
            end else begin
               ctx_next.reason   = REASON_MOTOR;
               ctx_next.seen_low = 1'b0;
               do_stop           = 1'b1;
            end
         end
      end else begin
         do_stop   = 1'b1;
         stop_mode = MODE_DISARMED;
      end

      if (do_stop) begin
         ctx_next.mode       = stop_mode;
         ctx_next.begin_tick = '0;
      end

      result.safety_state = ctx_next.mode;
      result.stop_reason  = ctx_next.reason;
      result.inhibit_cmd  = do_stop;
   end

endmodule

FILE: sv/aif_checker.sv
// port-level checks on the arming interlock result channel
`include "arming_interlock_fsm_defines.svh"

module aif_checker import aif_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_safety_state,
   input logic       rsp_inhibit_cmd,
   input logic       rsp_stop_cmd,
   input logic       rsp_authorize_cmd,
   input logic       rsp_zero_yaw_cmd,
   input logic       rsp_is_armed
);

   // a held beat must stay offered
   `AIF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // arming only follows an authorization request
   `AIF_ASSERT_NOW(a_yaw_auth, clock, reset, rsp_valid && rsp_zero_yaw_cmd, rsp_authorize_cmd && rsp_is_armed && !rsp_inhibit_cmd)

   // a stop command comes only on entering arming wait, never with inhibit or authorize
   `AIF_ASSERT_NOW(a_stop_wait, clock, reset, rsp_valid && rsp_stop_cmd, rsp_safety_state == MODE_WAIT && !rsp_inhibit_cmd && !rsp_authorize_cmd)

   // a stop lands in failsafe or disarmed
   `AIF_ASSERT_NOW(a_inhibit_mode, clock, reset, rsp_valid && rsp_inhibit_cmd, rsp_safety_state == MODE_FAILSAFE || rsp_safety_state == MODE_DISARMED)

endmodule

bind arming_interlock_fsm aif_checker u_aif_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_safety_state  (rsp_safety_state),
   .rsp_inhibit_cmd   (rsp_inhibit_cmd),
   .rsp_stop_cmd      (rsp_stop_cmd),
   .rsp_authorize_cmd (rsp_authorize_cmd),
   .rsp_zero_yaw_cmd  (rsp_zero_yaw_cmd),
   .rsp_is_armed      (rsp_is_armed)
);
